FILE: rtl/afrb_pkg.sv
`timescale 1ns / 1ps
// afrb_pkg: shared types and constants for the audio frame ring buffer.
// No dependencies; imported by every module of the block.
package afrb_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 2;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 13;
  localparam int CC_BITS      = 2;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [CC_BITS-1:0]   CC_RESET   = CC_BITS'(2);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(8192);

  // register index, taken from paddr[2]
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_READ_GAIN     = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_GAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ch1;
    logic signed [SAMPLE_BITS-1:0] ch0;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ch0;
    logic signed [SAMPLE_BITS-1:0] ch1;
    logic                          underrun;
    logic                          overwrote;
    logic                          saturated;
  } res_t;

endpackage

FILE: rtl/afrb_store.sv
`timescale 1ns / 1ps
// afrb_store: frame memory, one write port and one registered read port.
// Depends on afrb_pkg (frame_t).
module afrb_store import afrb_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  frame_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output frame_t        rdata
);

  frame_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/afrb_gain.sv
`timescale 1ns / 1ps
// afrb_gain: Q3.13 gain, product register then round half up and clamp.
// Depends on afrb_pkg (frame_t, res_t, widths).
module afrb_gain import afrb_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  frame_t               frame,
  input  logic [GAIN_BITS-1:0] gain,
  input  logic                 stereo,
  output res_t                 res
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int Y_W    = PROD_W + 1 - GAIN_FRAC;
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1 << (GAIN_FRAC - 1));
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [GAIN_BITS:0] gain_s;
  logic signed [PROD_W-1:0]  prod0;
  logic signed [PROD_W-1:0]  prod1;
  logic signed [SAMPLE_BITS-1:0] y0;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic sat0;
  logic sat1;

  assign gain_s = {1'b0, gain};

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= frame.ch0 * gain_s;
      prod1 <= frame.ch1 * gain_s;
    end
  end

  // upper bits of the rounded sum are the arithmetic shift; clip when they
  // do not all match the sign of the kept sample
  function automatic logic [SAMPLE_BITS:0] round_clip(input logic signed [PROD_W-1:0] p);
    logic [PROD_W:0]   sum;
    logic [Y_W-1:0]    y;
    logic [Y_W-SAMPLE_BITS:0] top;
    logic              ovf;
    sum = {p[PROD_W-1], p} + HALF;
    y   = sum[PROD_W:GAIN_FRAC];
    top = y[Y_W-1:SAMPLE_BITS-1];
    ovf = !((&top) || !(|top));
    if (ovf) begin
      round_clip = {1'b1, (y[Y_W-1] ? SMIN : SMAX)};
    end else begin
      round_clip = {1'b0, y[SAMPLE_BITS-1:0]};
    end
  endfunction

  assign {sat0, y0} = round_clip(prod0);
  assign {sat1, y1} = round_clip(prod1);

  always_comb begin
    res           = '0;
    res.ch0       = y0;
    res.ch1       = stereo ? y1 : '0;
    res.saturated = sat0 || (stereo && sat1);
  end

endmodule

FILE: rtl/afrb_out.sv
`timescale 1ns / 1ps
// afrb_out: result register that holds a transaction while the sink stalls.
// Depends on afrb_pkg (res_t).
module afrb_out import afrb_pkg::*; #(
  parameter int FILL_W = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  res_t                          res,
  input  logic [FILL_W-1:0]             fill,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_ch0,
  output logic signed [SAMPLE_BITS-1:0] out_ch1,
  output logic                          underrun,
  output logic                          overwrote,
  output logic                          saturated,
  output logic [FILL_W-1:0]             fill_level
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch0    <= res.ch0;
      out_ch1    <= res.ch1;
      underrun   <= res.underrun;
      overwrote  <= res.overwrote;
      saturated  <= res.saturated;
      fill_level <= fill;
    end
  end

endmodule

FILE: rtl/audio_frame_ring_buffer.sv
`timescale 1ns / 1ps
// audio_frame_ring_buffer: overwriting circular store of audio frames with
// a Q3.13 read gain. Depends on afrb_pkg, afrb_store, afrb_gain, afrb_out.
//
// One input transaction carries a command (write a frame, read the oldest
// frame, clear) and yields exactly one output transaction. The block works
// on one transaction at a time. A write, clear, empty read or unused
// command is loaded into the result register as it is accepted. A read of
// a held frame passes the memory read register, then the product register,
// and is then rounded and clipped into the result register. The next
// transaction can be accepted once the result has moved on into the output
// register, waiting first if the output register is not yet free.
// in_stall is high while a transaction is in progress; a new transaction
// is accepted while the previous result still waits in the output
// register. Writes to a full store drop the oldest frame and flag
// overwrote. Reads scale each sample by read_gain (8192 is unity),
// rounding half up and clipping to 16 bits signed with saturated set. A
// read of an empty store returns zeros with underrun set. fill_level
// reports the frames held after the transaction.
// Configuration (channel_count at 0x0, read_gain at 0x4) is to be written
// over the APB port only while the block is idle; the block itself does
// not enforce this. The frame memory needs no clearing after reset: only
// written entries are ever read.
module audio_frame_ring_buffer import afrb_pkg::*; #(
  parameter  int CAPACITY = 1024,
  localparam int AW       = $clog2(CAPACITY),
  localparam int FILL_W   = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] sample_ch1,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_ch0,
  output logic signed [SAMPLE_BITS-1:0] out_ch1,
  output logic                          underrun,
  output logic                          overwrote,
  output logic                          saturated,
  output logic [FILL_W-1:0]             fill_level
);

  localparam logic [AW-1:0]     LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(CAPACITY);

  // ---------------- configuration registers ----------------
  logic [CC_BITS-1:0]   channel_count;
  logic [GAIN_BITS-1:0] read_gain;
  logic                 reg_idx;
  logic                 cfg_wr;
  logic                 stereo;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign stereo  = (channel_count >= CC_BITS'(2)) && (MAX_CHANNELS >= 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CC_RESET;
      read_gain     <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CHANNEL_COUNT: channel_count <= pwdata[CC_BITS-1:0];
        REG_READ_GAIN:     read_gain     <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count);
      REG_READ_GAIN:     prdata = APB_DATA_W'(read_gain);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pointers and sequencing ----------------
  state_t            state, state_next;
  logic [AW-1:0]     read_index, read_index_next;
  logic [AW-1:0]     write_index, write_index_next;
  logic [FILL_W-1:0] held_frames, held_frames_next;
  logic              in_accept;
  logic              empty;
  logic              full;
  res_t              res_acc;
  res_t              res_gain;
  res_t              res;
  logic              mem_we, mem_re, gain_en;
  logic              res_load_acc, res_load_gain, out_load, out_free;
  frame_t            wframe;
  frame_t            rframe;

  assign in_accept = in_valid && !in_stall;
  assign empty     = (held_frames == '0);
  assign full      = (held_frames >= FULL);

  // pointer update and the result of everything but a held-frame read
  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    held_frames_next = held_frames;
    res_acc          = '0;
    if (in_accept) begin
      case (cmd)
        CMD_WRITE: begin
          write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
          if (full) begin
            // drop the oldest frame
            read_index_next   = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
            res_acc.overwrote = 1'b1;
          end else begin
            held_frames_next = held_frames + 1'b1;
          end
        end
        CMD_READ: begin
          if (empty) begin
            res_acc.underrun = 1'b1;
          end else begin
            read_index_next  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
            held_frames_next = held_frames - 1'b1;
          end
        end
        CMD_CLEAR: begin
          read_index_next  = '0;
          write_index_next = '0;
          held_frames_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      read_index  <= '0;
      write_index <= '0;
      held_frames <= '0;
    end else begin
      state       <= state_next;
      read_index  <= read_index_next;
      write_index <= write_index_next;
      held_frames <= held_frames_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (cmd == CMD_READ && !empty) ? ST_MEM : ST_EMIT;
        end
      end
      ST_MEM:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = 1'b1;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    gain_en       = 1'b0;
    res_load_acc  = 1'b0;
    res_load_gain = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        mem_we       = in_accept && (cmd == CMD_WRITE);
        mem_re       = in_accept && (cmd == CMD_READ) && !empty;
        res_load_acc = in_accept && !mem_re;
      end
      ST_MEM:  gain_en = 1'b1;
      ST_GAIN: res_load_gain = 1'b1;
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // mono frames keep channel 1 at zero so a later stereo read sees silence
  always_comb begin
    wframe.ch0 = sample_ch0;
    wframe.ch1 = stereo ? sample_ch1 : '0;
  end

  // pending result; only one transaction is in flight, so the memory never
  // sees a read and a write of the same entry overlap
  always_ff @(posedge clk) begin
    if (res_load_acc) begin
      res <= res_acc;
    end else if (res_load_gain) begin
      res <= res_gain;
    end
  end

  afrb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_index),
    .wdata (wframe),
    .re    (mem_re),
    .raddr (read_index),
    .rdata (rframe)
  );

  afrb_gain u_gain (
    .clk    (clk),
    .en     (gain_en),
    .frame  (rframe),
    .gain   (read_gain),
    .stereo (stereo),
    .res    (res_gain)
  );

  // held_frames already reflects this transaction when the result leaves
  afrb_out #(
    .FILL_W (FILL_W)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .res        (res),
    .fill       (held_frames),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_ch0    (out_ch0),
    .out_ch1    (out_ch1),
    .underrun   (underrun),
    .overwrote  (overwrote),
    .saturated  (saturated),
    .fill_level (fill_level)
  );

endmodule

FILE: rtl/afrb_checker.sv
`timescale 1ns / 1ps
// afrb_checker: port-level checks on the audio frame ring buffer.
// Depends on afrb_pkg; bound to audio_frame_ring_buffer below.
module afrb_checker import afrb_pkg::*; #(
  parameter  int CAPACITY = 1024,
  localparam int FILL_W   = $clog2(CAPACITY + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_ch0,
  input logic signed [SAMPLE_BITS-1:0] out_ch1,
  input logic                          underrun,
  input logic                          overwrote,
  input logic                          saturated,
  input logic [FILL_W-1:0]             fill_level
);

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction was in progress");

  a_underrun_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && underrun) |->
      (out_ch0 == '0 && out_ch1 == '0 && !saturated && !overwrote && fill_level == '0))
    else $error("underrun transaction carries data or flags");

  a_overwrote_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overwrote) |-> (fill_level == FILL_W'(CAPACITY)))
    else $error("overwrote reported with store not full");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_level <= FILL_W'(CAPACITY)))
    else $error("fill level above capacity");

endmodule

bind audio_frame_ring_buffer afrb_checker #(
  .CAPACITY (CAPACITY)
) u_afrb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_ch0    (out_ch0),
  .out_ch1    (out_ch1),
  .underrun   (underrun),
  .overwrote  (overwrote),
  .saturated  (saturated),
  .fill_level (fill_level)
);
